// ----- rtl/smx_pkg.sv -----
`default_nettype none

package smx_pkg;

  localparam int WORD_W          = 64;
  localparam int OPND_W          = 32;
  localparam int FUNC_W          = 2;
  localparam int IP_W            = 16;
  localparam int DEPTH_OUT_W     = 9;
  localparam int PLEN_W          = 16;
  localparam int STACK_DEPTH_DEF = 256;

  localparam int TDATA_IN_W  = ((FUNC_W + OPND_W + 7) / 8) * 8;
  localparam int RES_BITS    = 2 + WORD_W + 1 + IP_W + DEPTH_OUT_W;
  localparam int TDATA_OUT_W = ((RES_BITS + 7) / 8) * 8;

  localparam logic [IP_W-1:0] IP_MAX = '1;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH = 2'd0,
    FN_PLUS = 2'd1,
    FN_DUMP = 2'd2,
    FN_HALT = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_ILLEGAL   = 2'd3
  } status_t;

  typedef struct packed {
    status_t                status;
    logic [WORD_W-1:0]      dumped_value;
    logic                   dump_valid;
    logic                   stopped;
    logic [IP_W-1:0]        next_ip;
    logic [DEPTH_OUT_W-1:0] stack_depth;
  } smx_result_t;

endpackage

`default_nettype wire

// ----- rtl/smx_in_reg.sv -----
`default_nettype none

module smx_in_reg
  import smx_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [TDATA_IN_W-1:0] s_tdata,  // func, push_operand, zero pad
  input  wire logic                  take,
  output logic                       valid,
  output func_t                      func,
  output logic [OPND_W-1:0]          operand
);

  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func    <= func_t'(s_tdata[FUNC_W-1:0]);
      operand <= s_tdata[FUNC_W +: OPND_W];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/smx_stack_mem.sv -----
`default_nettype none

module smx_stack_mem
  import smx_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [WORD_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0]      rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first: a push lands exactly on the next read slot
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/smx_core.sv -----
`default_nettype none

module smx_core
  import smx_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int AW          = $clog2(STACK_DEPTH),
  parameter int SPW         = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [PLEN_W-1:0] cfg_data,
  input  wire logic              exec,
  input  wire func_t             func,
  input  wire logic [OPND_W-1:0] operand,
  input  wire logic [WORD_W-1:0] rd_data,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [WORD_W-1:0]      mem_wdata,
  output logic [AW-1:0]          mem_raddr,
  output smx_result_t            result
);

  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
  localparam logic [SPW-1:0] SP_ONE  = SPW'(1);
  localparam logic [SPW-1:0] SP_TWO  = SPW'(2);
  localparam logic [SPW-1:0] SP_TRI  = SPW'(3);

  // top = entry sp-1, second = entry sp-2, memory holds the rest;
  // rd_data always holds entry sp-3
  logic [PLEN_W-1:0] program_length;
  logic [SPW-1:0]    sp, sp_next;
  logic [IP_W-1:0]   ip, ip_next;
  logic [WORD_W-1:0] top, top_next;
  logic [WORD_W-1:0] second, second_next;
  logic              stopped, stopped_next;
  status_t           fstat, fstat_next;
  logic [WORD_W-1:0] opnd_ext;
  logic [WORD_W-1:0] dumped;
  logic              dval;
  logic [SPW-1:0]    waddr_full, raddr_full;

  assign opnd_ext = {{(WORD_W-OPND_W){operand[OPND_W-1]}}, operand};

  always_comb begin
    sp_next      = sp;
    ip_next      = ip;
    top_next     = top;
    second_next  = second;
    stopped_next = stopped;
    fstat_next   = fstat;
    mem_we       = 1'b0;
    dumped       = '0;
    dval         = 1'b0;
    if (exec && !stopped) begin
      fstat_next   = ST_OK;
      stopped_next = 1'b0;
      if (ip >= program_length) begin
        fstat_next   = ST_ILLEGAL;
        stopped_next = 1'b1;
      end else begin
        if (ip != IP_MAX) begin
          ip_next = ip + IP_W'(1);
        end
        unique case (func)
          FN_PUSH: begin
            if (sp >= SP_FULL) begin
              fstat_next   = ST_OVERFLOW;
              stopped_next = 1'b1;
            end else begin
              top_next    = opnd_ext;
              second_next = top;
              sp_next     = sp + SP_ONE;
              mem_we      = (sp >= SP_TWO);
            end
          end
          FN_PLUS: begin
            if (sp < SP_TWO) begin
              // fewer than two words: a lone word is still popped
              fstat_next   = ST_UNDERFLOW;
              stopped_next = 1'b1;
              sp_next      = '0;
            end else begin
              top_next    = top + second;
              second_next = rd_data;
              sp_next     = sp - SP_ONE;
            end
          end
          FN_DUMP: begin
            if (sp == '0) begin
              fstat_next   = ST_UNDERFLOW;
              stopped_next = 1'b1;
            end else begin
              dumped      = top;
              dval        = 1'b1;
              top_next    = second;
              second_next = rd_data;
              sp_next     = sp - SP_ONE;
            end
          end
          FN_HALT: begin
            stopped_next = 1'b1;
          end
          default: begin
            stopped_next = 1'b1;
          end
        endcase
      end
    end
  end

  assign waddr_full = sp - SP_TWO;
  assign raddr_full = sp_next - SP_TRI;
  assign mem_waddr  = waddr_full[AW-1:0];
  assign mem_wdata  = second;
  assign mem_raddr  = raddr_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
      sp             <= '0;
      ip             <= '0;
      stopped        <= 1'b0;
      fstat          <= ST_OK;
    end else begin
      if (cfg_we) begin
        program_length <= cfg_data;
      end
      sp      <= sp_next;
      ip      <= ip_next;
      stopped <= stopped_next;
      fstat   <= fstat_next;
    end
  end

  always_ff @(posedge clk) begin
    top    <= top_next;
    second <= second_next;
  end

  always_comb begin
    result.status       = fstat_next;
    result.dumped_value = dumped;
    result.dump_valid   = dval;
    result.stopped      = stopped_next;
    result.next_ip      = ip_next;
    result.stack_depth  = DEPTH_OUT_W'(sp_next);
  end

endmodule

`default_nettype wire

// ----- rtl/smx_out_reg.sv -----
`default_nettype none

module smx_out_reg
  import smx_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire smx_result_t            result,
  output logic                        can_load,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // status, dumped_value, stopped, next_ip, stack_depth, zero pad
  output logic [TDATA_OUT_W-1:0]      m_tdata,
  output logic                        m_tuser  // dump_valid
);

  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {{(TDATA_OUT_W-RES_BITS){1'b0}}, result.stack_depth, result.next_ip,
                  result.stopped, result.dumped_value, result.status};
      m_tuser <= result.dump_valid;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/stack_machine_executor_unit.sv -----
// An accepted input word waits in the input register, then is executed in one step
// into the result register once that register can load. Throughput: one word per
// cycle while m_tready does not stall the result; while a result waits, the input
// register takes one more word and holds it. Reset (rst, synchronous) clears stack
// pointer, instruction pointer, stopped flag, status, program_length and both valid
// flags; stack contents are not cleared.
`default_nettype none

module stack_machine_executor_unit
  import smx_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [PLEN_W-1:0]      cfg_data,   // program_length
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [TDATA_IN_W-1:0]  s_tdata,    // func, push_operand, zero pad
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // status, dumped_value, stopped, next_ip, stack_depth, zero pad
  output logic [TDATA_OUT_W-1:0]      m_tdata,
  output logic                        m_tuser     // dump_valid
);

  localparam int AW = $clog2(STACK_DEPTH);

  logic              in_valid;
  func_t             in_func;
  logic [OPND_W-1:0] in_operand;
  logic              can_load;
  logic              exec;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;
  smx_result_t       result;

  assign exec = in_valid && can_load;

  smx_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (exec),
    .valid    (in_valid),
    .func     (in_func),
    .operand  (in_operand)
  );

  smx_core #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .exec      (exec),
    .func      (in_func),
    .operand   (in_operand),
    .rd_data   (mem_rdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .result    (result)
  );

  smx_stack_mem #(
    .DEPTH (STACK_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  smx_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (exec),
    .result   (result),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

// ----- rtl/smx_checker.sv -----
`default_nettype none

module smx_checker
  import smx_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [TDATA_OUT_W-1:0] m_tdata,
  input wire logic                   m_tuser
);

  localparam int STOP_BIT = 2 + WORD_W;

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_no_word_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result word right after reset");

  a_error_stops: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != ST_OK) |-> m_tdata[STOP_BIT])
    else $error("error status without stop");

  a_dump_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[1:0] == ST_OK) && !m_tdata[STOP_BIT])
    else $error("dump flagged on a failed or stopped step");

  a_dump_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[STOP_BIT-1:2] == '0))
    else $error("dumped value nonzero without dump");

endmodule

bind stack_machine_executor_unit smx_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- sim/tb_stack_machine_executor_unit.sv -----
`default_nettype none

module tb_stack_machine_executor_unit;
  import smx_pkg::*;

  localparam int STACK_N = STACK_DEPTH_DEF;

  typedef struct {
    status_t              status;
    logic [WORD_W-1:0]    dumped;
    logic                 dvalid;
    logic                 stopped;
    logic [IP_W-1:0]      ip;
    logic [DEPTH_OUT_W-1:0] depth;
  } vm_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [PLEN_W-1:0]      cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [TDATA_IN_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic                   m_tuser;

  // shadow of the machine
  logic [WORD_W-1:0] stack_mem [STACK_N];
  int                depth_cnt = 0;
  logic [IP_W-1:0]   ip_cnt = '0;
  logic [PLEN_W-1:0] plen_reg = '0;
  logic              halted = 1'b0;
  status_t           last_status = ST_OK;

  vm_result_t pending_results [$];
  int         err_cnt = 0;
  bit         calm = 1'b0;

  stack_machine_executor_unit #(
    .STACK_DEPTH(STACK_N)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  task automatic report(string what);
    err_cnt++;
    if (err_cnt <= 50) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  task automatic execute_instruction(func_t f, logic [OPND_W-1:0] opnd);
    vm_result_t r;
    status_t st;
    logic stop;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    r.dumped = '0;
    r.dvalid = 1'b0;
    if (!halted) begin
      st = ST_OK;
      stop = 1'b0;
      if (ip_cnt >= plen_reg) begin
        st = ST_ILLEGAL;
        stop = 1'b1;
      end else begin
        if (ip_cnt != IP_MAX) ip_cnt++;
        case (f)
          FN_PUSH: begin
            if (depth_cnt >= STACK_N) begin
              st = ST_OVERFLOW;
              stop = 1'b1;
            end else begin
              stack_mem[depth_cnt] = {{(WORD_W-OPND_W){opnd[OPND_W-1]}}, opnd};
              depth_cnt++;
            end
          end
          FN_PLUS: begin
            if (depth_cnt < 2) begin
              // fewer than two words: a lone word is still popped before the second pop fails
              st = ST_UNDERFLOW;
              stop = 1'b1;
              depth_cnt = 0;
            end else begin
              a = stack_mem[depth_cnt-1];
              b = stack_mem[depth_cnt-2];
              depth_cnt--;
              stack_mem[depth_cnt-1] = a + b;
            end
          end
          FN_DUMP: begin
            if (depth_cnt == 0) begin
              st = ST_UNDERFLOW;
              stop = 1'b1;
            end else begin
              depth_cnt--;
              r.dumped = stack_mem[depth_cnt];
              r.dvalid = 1'b1;
            end
          end
          default: stop = 1'b1;
        endcase
      end
      last_status = st;
      halted = stop;
    end
    r.status = last_status;
    r.stopped = halted;
    r.ip = ip_cnt;
    r.depth = depth_cnt[DEPTH_OUT_W-1:0];
    pending_results.push_back(r);
  endtask

  task automatic send_word(func_t f, logic [OPND_W-1:0] opnd);
    if (!calm) begin
      while ($urandom_range(99) < 8) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(TDATA_IN_W-OPND_W-FUNC_W){1'b0}}, opnd, f};
    do @(posedge clk); while (!s_tready);
    execute_instruction(f, opnd);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_plen(logic [PLEN_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    plen_reg = v;
  endtask

  function automatic logic [OPND_W-1:0] rand_operand();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // only ops that keep the machine running
  function automatic func_t pick_legal_op(int push_w);
    int r;
    r = $urandom_range(99);
    if (depth_cnt == 0) return FN_PUSH;
    if (depth_cnt >= STACK_N) return ($urandom_range(1) != 0) ? FN_PLUS : FN_DUMP;
    if (r < push_w) return FN_PUSH;
    if (depth_cnt >= 2 && r[0]) return FN_PLUS;
    return FN_DUMP;
  endfunction

  task automatic test_directed();
    func_t ops [20] = '{FN_PUSH, FN_PUSH, FN_PLUS, FN_DUMP, FN_PUSH, FN_PUSH, FN_PLUS,
                        FN_PUSH, FN_PLUS, FN_DUMP, FN_PUSH, FN_PUSH, FN_PUSH, FN_PLUS,
                        FN_PLUS, FN_PUSH, FN_PLUS, FN_DUMP, FN_PUSH, FN_DUMP};
    logic [OPND_W-1:0] vals [20] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0,
                                     32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'hAAAA_AAAA,
                                     32'h5555_5555, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0,
                                     32'h0, 32'hFFFF_FFFF, 32'h1234_5678};
    // program is exactly as long as the sequence: last word sits on the bound
    write_plen(PLEN_W'(20));
    foreach (ops[i]) send_word(ops[i], vals[i]);
  endtask

  task automatic test_full_stack();
    drain();
    write_plen('1);
    while (depth_cnt < STACK_N) send_word(FN_PUSH, rand_operand());
    repeat (40) send_word(pick_legal_op(50), rand_operand());
  endtask

  task automatic test_random_program(int n, bit quiet, int slack);
    int lim;
    int push_w;
    drain();
    lim = ip_cnt + n + slack;
    if (lim > 65535) lim = 65535;
    write_plen(PLEN_W'(lim));
    calm = quiet;
    push_w = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(2))
          0: push_w = 15;
          1: push_w = 50;
          default: push_w = 85;
        endcase
      end
      send_word(pick_legal_op(push_w), rand_operand());
    end
    calm = 1'b0;
  endtask

  task automatic test_stop_condition();
    int kind;
    kind = $urandom_range(6);
    drain();
    write_plen('1);
    case (kind)
      0: begin
        while (depth_cnt < STACK_N) send_word(FN_PUSH, rand_operand());
        send_word(FN_PUSH, rand_operand());
      end
      1: begin
        while (depth_cnt > 0) send_word(FN_DUMP, rand_operand());
        send_word(FN_PLUS, rand_operand());
      end
      2: begin
        while (depth_cnt > 0) send_word(FN_DUMP, rand_operand());
        send_word(FN_PUSH, rand_operand());
        send_word(FN_PLUS, rand_operand());
      end
      3: begin
        while (depth_cnt > 0) send_word(FN_DUMP, rand_operand());
        send_word(FN_DUMP, rand_operand());
      end
      4: send_word(FN_HALT, rand_operand());
      5: begin
        @(posedge clk);
        write_plen(ip_cnt);
        send_word(func_t'($urandom_range(3)), rand_operand());
      end
      default: begin
        @(posedge clk);
        write_plen(PLEN_W'($urandom_range(ip_cnt)));
        send_word(func_t'($urandom_range(3)), rand_operand());
      end
    endcase
    // stopped must win over the fetch bound: zero length, status still repeats
    drain();
    write_plen('0);
    repeat (12) send_word(func_t'($urandom_range(3)), rand_operand());
  endtask

  task automatic check_result();
    vm_result_t e;
    if (pending_results.size() == 0) begin
      report("result word with nothing expected");
      return;
    end
    e = pending_results.pop_front();
    // m_tdata: status[1:0], dumped_value[65:2], stopped[66], next_ip[82:67],
    // stack_depth[91:83]
    if (m_tdata[1:0] !== e.status)
      report($sformatf("status got %0d exp %0d", m_tdata[1:0], e.status));
    if (m_tdata[65:2] !== e.dumped)
      report($sformatf("dumped_value got %h exp %h", m_tdata[65:2], e.dumped));
    if (m_tuser !== e.dvalid)
      report($sformatf("dump_valid got %b exp %b", m_tuser, e.dvalid));
    if (m_tdata[66] !== e.stopped)
      report($sformatf("stopped got %b exp %b", m_tdata[66], e.stopped));
    if (m_tdata[82:67] !== e.ip)
      report($sformatf("next_ip got %0d exp %0d", m_tdata[82:67], e.ip));
    if (m_tdata[91:83] !== e.depth)
      report($sformatf("stack_depth got %0d exp %0d", m_tdata[91:83], e.depth));
  endtask

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result();
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_stack();
    test_random_program(150, 1'b0, 70000);
    test_random_program(150, 1'b1, 0);
    test_random_program(150, 1'b0, $urandom_range(2000, 1));
    test_stop_condition();
    drain();
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
